/* rtl/skpw_pkg.sv */
// skpw_pkg: shared constants, register and item codes, divider request and response structs and
// the variable-byte length function for the multilevel skip point writer.
// No dependencies.
package skpw_pkg;

	// default depth of the per-level store
	localparam int unsigned DEF_MAX_LEVELS = 8;

	// field widths
	localparam int unsigned DOC_W      = 32;
	localparam int unsigned OFS_W      = 64;
	localparam int unsigned BYTES_W    = 32;
	localparam int unsigned COUNT_W    = 32;
	localparam int unsigned LEVEL_W    = 3;
	localparam int unsigned INTERVAL_W = 9;
	localparam int unsigned MAXLEV_W   = 4;
	localparam int unsigned LEN_W      = 4;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = INTERVAL_W;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_INTERVAL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVELS    = 1'd1;

	// configuration reset values
	localparam logic [INTERVAL_W-1:0] RST_SKIP_INTERVAL = 9'd16;
	localparam logic [MAXLEV_W-1:0]   RST_MAX_LEVELS    = 4'd8;

	// request kinds
	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	// per-level entry layout: last doc, last posting offset, last position offset, bytes
	localparam int unsigned ENTRY_W = DOC_W + OFS_W + OFS_W + BYTES_W;

	// divider: bits retired per cycle and steps per division
	localparam int unsigned DIV_STEP_BITS = 4;
	localparam int unsigned DIV_STEPS     = COUNT_W / DIV_STEP_BITS;
	localparam int unsigned DIV_CNT_W     = $clog2(DIV_STEPS);

	typedef struct packed {
		logic                  start;
		logic [COUNT_W-1:0]    dividend;
		logic [INTERVAL_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [COUNT_W-1:0]    quotient;
		logic [INTERVAL_W-1:0] remainder;
	} div_rsp_t;

	// length of a value in 7-bit groups, at least one
	function automatic logic [LEN_W-1:0] leb_len(input logic [OFS_W-1:0] v);
		logic [LEN_W-1:0] n;
		n = LEN_W'(1);
		for (int k = 1; k < 10; k++) begin
			if ((v >> (7 * k)) != '0) begin
				n = LEN_W'(k + 1);
			end
		end
		return n;
	endfunction

endpackage

/* rtl/skpw_if.sv */
// skpw_if: handshake channels of the skip point writer: points in, records
// out, and the configuration write channel. Depends on skpw_pkg.
interface skpw_point_if import skpw_pkg::*;;
	logic             valid;
	logic             ready;
	logic             kind;
	logic [DOC_W-1:0] doc_id;
	logic [OFS_W-1:0] post_offset;
	logic [OFS_W-1:0] pos_offset;

	modport source (output valid, kind, doc_id, post_offset, pos_offset, input ready);
	modport sink   (input valid, kind, doc_id, post_offset, pos_offset, output ready);
endinterface

interface skpw_rec_if import skpw_pkg::*;;
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] level;
	logic [DOC_W-1:0]   doc_delta_x2;
	logic [OFS_W-1:0]   offset_delta;
	logic [OFS_W-1:0]   pos_delta;
	logic               has_child;
	logic [BYTES_W-1:0] child_pointer;
	logic               last;

	modport source (output valid, level, doc_delta_x2, offset_delta, pos_delta, has_child,
		child_pointer, last, input ready);
	modport sink   (input valid, level, doc_delta_x2, offset_delta, pos_delta, has_child,
		child_pointer, last, output ready);
endinterface

interface skpw_cfg_if import skpw_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/skpw_ram.sv */
// skpw_ram: generic single-port-write, single-port-read memory with a
// registered read. No dependencies.
module skpw_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/skpw_div.sv */
// skpw_div: radix-16 restoring divider of the point count by the skip
// interval, four quotient bits a cycle. Depends on skpw_pkg.
module skpw_div import skpw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [COUNT_W-1:0]    work_q;
	logic [INTERVAL_W-1:0] rem_q;
	logic [INTERVAL_W-1:0] dvs_q;
	logic [COUNT_W-1:0]    work_d;
	logic [INTERVAL_W-1:0] rem_d;

	// four compare-subtract steps on the narrow remainder
	always_comb begin
		logic [INTERVAL_W:0] t;
		work_d = work_q;
		rem_d  = rem_q;
		for (int i = 0; i < DIV_STEP_BITS; i++) begin
			t      = {rem_d, work_d[COUNT_W-1]};
			work_d = {work_d[COUNT_W-2:0], 1'b0};
			if (t >= {1'b0, dvs_q}) begin
				rem_d     = INTERVAL_W'(t - {1'b0, dvs_q});
				work_d[0] = 1'b1;
			end else begin
				rem_d = t[INTERVAL_W-1:0];
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operands and partial results
	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= req.dividend;
			rem_q  <= '0;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			work_q <= work_d;
			rem_q  <= rem_d;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = work_q;
	assign rsp.remainder = rem_q;

`ifndef SYNTHESIS
	// a new division never starts on top of a running one
	assert property (@(posedge clk) disable iff (!arst_n) req.start |-> !busy_q)
		else $error("divider restarted while busy");
	// done follows the last step of a busy period
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> $past(busy_q))
		else $error("divider done without a busy period");
	// a zero divisor is never taken
	assert property (@(posedge clk) disable iff (!arst_n) req.start |-> req.divisor != '0)
		else $error("divider started with zero divisor");
`endif

endmodule

/* rtl/multilevel_skip_point_writer_top.sv */
// multilevel_skip_point_writer_top: sequencer, per-level store and record
// output of the skip point writer. Depends on skpw_pkg, skpw_if, skpw_ram, skpw_div.
//
// channel   dir   handshake      payload
// points    in    valid/ready    kind, doc_id, post_offset, pos_offset
// records   out   valid/ready    level, deltas, has_child, child_pointer, last
// cfg       in    valid/ready    index, data (always ready)
//
// A clear request is done in the idle state; an add request for L levels first runs the
// level search in the count divider (four quotient bits a cycle), with L divisions when
// a remainder ends the search, L - 1 when the level limit does, none for interval zero or
// one level, then per record read (store read), execute (delta), emit (write back, output).
// Reset clears the count and the per-level valid bits; no clearing pass.
// A record waiting in the output register stalls only the next record.
module multilevel_skip_point_writer_top import skpw_pkg::*; #(
	parameter int unsigned MAX_LEVELS = DEF_MAX_LEVELS
) (
	input  logic clk,
	input  logic arst_n,
	skpw_point_if.sink points,
	skpw_rec_if.source records,
	skpw_cfg_if.sink   cfg
);

	localparam int unsigned LW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int unsigned LCW = $clog2(MAX_LEVELS + 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_RD   = 5'b00100,
		ST_EXE  = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t                state_q;
	logic [INTERVAL_W-1:0] skip_interval_q;
	logic [MAXLEV_W-1:0]   max_levels_q;
	logic [COUNT_W-1:0]    point_count_q;
	logic [COUNT_W-1:0]    n_q;
	logic [LCW-1:0]        levels_q;
	logic [LCW-1:0]        limit_q;
	logic [LW-1:0]         lv_q;
	logic [MAX_LEVELS-1:0] valid_q;
	logic [DOC_W-1:0]      doc_q;
	logic [OFS_W-1:0]      post_q;
	logic [OFS_W-1:0]      pos_q;
	logic [DOC_W-1:0]      dd_q;
	logic [OFS_W-1:0]      od_q;
	logic [OFS_W-1:0]      pd_q;
	logic [BYTES_W-1:0]    bytes_q;
	logic [BYTES_W-1:0]    child_q;

	// output register
	logic                  rec_valid_q;
	logic [LEVEL_W-1:0]    rec_level_q;
	logic [DOC_W-1:0]      rec_dd_q;
	logic [OFS_W-1:0]      rec_od_q;
	logic [OFS_W-1:0]      rec_pd_q;
	logic                  rec_has_child_q;
	logic [BYTES_W-1:0]    rec_child_q;
	logic                  rec_last_q;

	logic                  accept;
	logic                  accept_add;
	logic [4:0]            lim5;
	logic [LCW-1:0]        limit_d;
	logic                  out_free;
	logic                  emit;
	logic                  lv_is_last;
	logic [LCW-1:0]        levels_inc;
	div_req_t              div_req;
	div_rsp_t              div_rsp;
	logic                  ram_we;
	logic [ENTRY_W-1:0]    ram_wdata;
	logic [ENTRY_W-1:0]    ram_rdata;
	logic [ENTRY_W-1:0]    entry;
	logic [BYTES_W:0]      below_sum;
	logic [BYTES_W-1:0]    below;
	logic [BYTES_W:0]      bytes_sum;
	logic [BYTES_W-1:0]    bytes_new;

	// handshakes
	assign points.ready = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign accept       = points.valid && points.ready;
	assign accept_add   = accept && (points.kind == KIND_ADD);

	// level limit from the register, held within one and the store depth
	always_comb begin
		if (max_levels_q == '0) begin
			lim5 = 5'd1;
		end else if ({1'b0, max_levels_q} > 5'(MAX_LEVELS)) begin
			lim5 = 5'(MAX_LEVELS);
		end else begin
			lim5 = {1'b0, max_levels_q};
		end
	end
	assign limit_d = LCW'(lim5);

	assign levels_inc = levels_q + 1'b1;
	assign lv_is_last = (LCW'(lv_q) + 1'b1 == levels_q);
	assign out_free   = !rec_valid_q || records.ready;
	assign emit       = (state_q == ST_EMIT) && out_free;

	// divider requests: first on an accepted add, then after each even division below the limit
	always_comb begin
		div_req.dividend = accept_add ? point_count_q + 1'b1 : div_rsp.quotient;
		div_req.divisor  = skip_interval_q;
		div_req.start    = 1'b0;
		if (accept_add) begin
			div_req.start = (skip_interval_q != '0) && (limit_d > LCW'(1));
		end else if (state_q == ST_DIV && div_rsp.done && div_rsp.remainder == '0) begin
			div_req.start = (levels_inc < limit_q);
		end
	end

	skpw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// per-level store; an entry never written reads as zero
	skpw_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_LEVELS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (lv_q),
		.wdata (ram_wdata),
		.re    (state_q == ST_RD),
		.raddr (lv_q),
		.rdata (ram_rdata)
	);
	assign entry = valid_q[lv_q] ? ram_rdata : '0;

	// byte lengths: up to the data values, then with the child pointer
	always_comb begin
		below_sum = {1'b0, bytes_q} + (BYTES_W + 1)'(leb_len(OFS_W'(dd_q)))
			+ (BYTES_W + 1)'(leb_len(od_q)) + (BYTES_W + 1)'(leb_len(pd_q));
		below     = below_sum[BYTES_W] ? '1 : below_sum[BYTES_W-1:0];
		bytes_sum = {1'b0, below} + (BYTES_W + 1)'(leb_len(OFS_W'(child_q)));
		if (lv_q == '0) begin
			bytes_new = below;
		end else begin
			bytes_new = bytes_sum[BYTES_W] ? '1 : bytes_sum[BYTES_W-1:0];
		end
	end
	assign ram_we    = emit;
	assign ram_wdata = {doc_q, post_q, pos_q, bytes_new};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_interval_q <= RST_SKIP_INTERVAL;
			max_levels_q    <= RST_MAX_LEVELS;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_SKIP_INTERVAL: skip_interval_q <= cfg.data;
				REG_MAX_LEVELS:    max_levels_q    <= cfg.data[MAXLEV_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			point_count_q <= '0;
			valid_q       <= '0;
			levels_q      <= '0;
			limit_q       <= '0;
			lv_q          <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (points.kind == KIND_CLEAR) begin
							point_count_q <= '0;
							valid_q       <= '0;
						end else begin
							point_count_q <= point_count_q + 1'b1;
							levels_q      <= LCW'(1);
							limit_q       <= limit_d;
							lv_q          <= '0;
							state_q       <= div_req.start ? ST_DIV : ST_RD;
						end
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						if (div_rsp.remainder == '0) begin
							levels_q <= levels_inc;
						end
						if (!div_req.start) begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_EXE;
				end
				ST_EXE: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						valid_q[lv_q] <= 1'b1;
						if (lv_is_last) begin
							state_q <= ST_IDLE;
						end else begin
							lv_q    <= lv_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// point payload, deltas and running child pointer
	always_ff @(posedge clk) begin
		if (accept_add) begin
			doc_q   <= points.doc_id;
			post_q  <= points.post_offset;
			pos_q   <= points.pos_offset;
			child_q <= '0;
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			n_q <= div_rsp.quotient;
		end
		if (state_q == ST_EXE) begin
			dd_q    <= (doc_q - entry[ENTRY_W-1 -: DOC_W]) << 1;
			od_q    <= post_q - entry[2*OFS_W+BYTES_W-1 -: OFS_W];
			pd_q    <= pos_q - entry[OFS_W+BYTES_W-1 -: OFS_W];
			bytes_q <= entry[BYTES_W-1:0];
		end
		if (emit) begin
			child_q <= below;
		end
	end

	// record output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (emit) begin
			rec_valid_q <= 1'b1;
		end else if (records.ready) begin
			rec_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rec_level_q     <= LEVEL_W'(lv_q);
			rec_dd_q        <= dd_q;
			rec_od_q        <= od_q;
			rec_pd_q        <= pd_q;
			rec_has_child_q <= (lv_q != '0);
			rec_child_q     <= (lv_q != '0) ? child_q : '0;
			rec_last_q      <= lv_is_last;
		end
	end

	assign records.valid         = rec_valid_q;
	assign records.level         = rec_level_q;
	assign records.doc_delta_x2  = rec_dd_q;
	assign records.offset_delta  = rec_od_q;
	assign records.pos_delta     = rec_pd_q;
	assign records.has_child     = rec_has_child_q;
	assign records.child_pointer = rec_child_q;
	assign records.last          = rec_last_q;

`ifndef SYNTHESIS
	// the store is written only while records go out
	assert property (@(posedge clk) disable iff (!arst_n) ram_we |-> state_q == ST_EMIT)
		else $error("store written outside record phase");
	// divider results arrive only while the sequencer waits for them
	assert property (@(posedge clk) disable iff (!arst_n) div_rsp.done |-> state_q == ST_DIV)
		else $error("divider result outside level search");
	// the record level stays below the level count of the point
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_EXE || state_q == ST_EMIT)
		|-> (LCW'(lv_q) < levels_q && levels_q <= limit_q))
		else $error("record level out of range");
	// a clear leaves no valid entry and a zero count
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && points.kind == KIND_CLEAR) |=> (valid_q == '0 && point_count_q == '0))
		else $error("clear left state behind");
	// the quotient captured at the end of the level search is the last divider quotient
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD && $past(state_q) == ST_DIV) |-> n_q == $past(div_rsp.quotient))
		else $error("level search quotient lost");
`endif

endmodule
